### src/rtwp_pkg.sv
// Shared types, codes and the worker ranking function for the tiered worker pick.
package rtwp_pkg;

    localparam int WORKER_ID_BITS = 16;
    localparam int COUNTER_BITS   = 32;
    localparam int KEY_BITS       = 32;
    localparam int BYTES_BITS     = 48;
    localparam int COUNT_IN_BITS  = 16;
    localparam int LOAD_BITS      = COUNT_IN_BITS + 1;
    localparam int RANK_BITS      = 2;
    localparam int MODE_BITS      = 2;
    localparam int NUM_TIERS      = 3;

    localparam logic [MODE_BITS-1:0] MODE_HEADER   = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_SNAPSHOT = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_RESIDENT = 2'd2;

    localparam logic [RANK_BITS-1:0] RANK_RESIDENT = 2'd0;
    localparam logic [RANK_BITS-1:0] RANK_FIT      = 2'd1;
    localparam logic [RANK_BITS-1:0] RANK_EVICT    = 2'd2;
    localparam logic [RANK_BITS-1:0] RANK_NONE     = 2'd3;

    localparam logic STATUS_CHOSEN = 1'b0;
    localparam logic STATUS_NONE   = 1'b1;

    typedef struct packed {
        logic                      valid;
        logic [WORKER_ID_BITS-1:0] id;
        logic                      feasible;
        logic                      fits_free;
        logic                      resident;
        logic [LOAD_BITS-1:0]      load;
    } pend_t;

    typedef struct packed {
        logic                      valid;
        logic [WORKER_ID_BITS-1:0] worker;
        logic [RANK_BITS-1:0]      rank;
        logic [LOAD_BITS-1:0]      weight;
    } best_t;

    localparam pend_t PEND_CLEAR = '{
        valid:     1'b0,
        id:        '0,
        feasible:  1'b0,
        fits_free: 1'b0,
        resident:  1'b0,
        load:      '0
    };

    localparam best_t BEST_CLEAR = '{
        valid:  1'b0,
        worker: '0,
        rank:   RANK_NONE,
        weight: '1
    };

    function automatic best_t fold_worker(best_t b, pend_t p);
        best_t                r;
        logic [RANK_BITS-1:0] tier;
        logic                 better;
        r = b;
        tier = p.resident ? RANK_RESIDENT : (p.fits_free ? RANK_FIT : RANK_EVICT);
        better = !b.valid || (tier < b.rank)
            || ((tier == b.rank) && (p.load < b.weight))
            || ((tier == b.rank) && (p.load == b.weight) && (p.id < b.worker));
        if (p.valid && p.feasible && better)
        begin
            r.valid  = 1'b1;
            r.worker = p.id;
            r.rank   = tier;
            r.weight = p.load;
        end
        return r;
    endfunction

endpackage

### src/residency_tiered_worker_pick.sv
// Tiered least-loaded worker pick: input register, single-pass evaluation, result register.
//
// Takes one request item per cycle and, on an item marked last, presents the
// result in the result register once that item leaves the input register. Items without
// last never hold up the input; in_stall rises only when a last item waits in the input
// register while the result register is full and stalled. The rate is set by the one
// evaluation stage, which ranks the pending worker against the best one so far and
// updates the running choice as each item advances and the tier counters on each last one.
module residency_tiered_worker_pick (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [rtwp_pkg::MODE_BITS-1:0]       mode,
    input  logic [rtwp_pkg::KEY_BITS-1:0]        key_id,
    input  logic [rtwp_pkg::BYTES_BITS-1:0]      model_bytes,
    input  logic [rtwp_pkg::WORKER_ID_BITS-1:0]  worker_ident,
    input  logic                                 accepting,
    input  logic [rtwp_pkg::BYTES_BITS-1:0]      budget_bytes,
    input  logic [rtwp_pkg::BYTES_BITS-1:0]      used_bytes,
    input  logic [rtwp_pkg::COUNT_IN_BITS-1:0]   queued,
    input  logic [rtwp_pkg::COUNT_IN_BITS-1:0]   active,
    input  logic                                 last,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 status,
    output logic [rtwp_pkg::WORKER_ID_BITS-1:0]  chosen_worker,
    output logic [rtwp_pkg::RANK_BITS-1:0]       chosen_tier,
    output logic [rtwp_pkg::COUNTER_BITS-1:0]    resident_picks,
    output logic [rtwp_pkg::COUNTER_BITS-1:0]    fit_picks,
    output logic [rtwp_pkg::COUNTER_BITS-1:0]    evict_picks
);
    import rtwp_pkg::*;

    // input register
    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    logic [MODE_BITS-1:0]      s1_mode_reg;
    logic [KEY_BITS-1:0]       s1_key_reg;
    logic [BYTES_BITS-1:0]     s1_model_bytes_reg;
    logic [WORKER_ID_BITS-1:0] s1_ident_reg;
    logic                      s1_accepting_reg;
    logic [BYTES_BITS-1:0]     s1_budget_reg;
    logic [BYTES_BITS-1:0]     s1_free_reg;
    logic [LOAD_BITS-1:0]      s1_load_reg;
    logic                      s1_last_reg;

    // request state
    logic [KEY_BITS-1:0]       req_model_id_reg;
    logic [KEY_BITS-1:0]       req_model_id_next;
    logic [BYTES_BITS-1:0]     req_model_bytes_reg;
    logic [BYTES_BITS-1:0]     req_model_bytes_next;
    pend_t                     pend_reg;
    pend_t                     pend_next;
    best_t                     best_reg;
    best_t                     best_next;
    logic [COUNTER_BITS-1:0]   cnt_reg [NUM_TIERS];
    logic [COUNTER_BITS-1:0]   cnt_next [NUM_TIERS];

    // result register
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      status_reg;
    logic [WORKER_ID_BITS-1:0] chosen_worker_reg;
    logic [RANK_BITS-1:0]      chosen_tier_reg;
    logic [COUNTER_BITS-1:0]   resident_picks_reg;
    logic [COUNTER_BITS-1:0]   fit_picks_reg;
    logic [COUNTER_BITS-1:0]   evict_picks_reg;

    logic                      advance;
    logic                      take_in;
    logic [BYTES_BITS:0]       free_diff;
    logic [BYTES_BITS-1:0]     free_in;
    pend_t                     pend_fresh;
    pend_t                     pend_item;
    best_t                     best_item;
    best_t                     best_folded;
    best_t                     best_final;

    assign advance  = s1_valid_reg && (!s1_last_reg || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    assign free_diff = {1'b0, budget_bytes} - {1'b0, used_bytes};
    assign free_in   = free_diff[BYTES_BITS] ? '0 : free_diff[BYTES_BITS-1:0];

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (!in_stall)
        begin
            s1_valid_next = in_valid;
        end
    end

    always_comb
    begin
        pend_fresh.valid     = 1'b1;
        pend_fresh.id        = s1_ident_reg;
        pend_fresh.feasible  = s1_accepting_reg && (req_model_bytes_reg <= s1_budget_reg);
        pend_fresh.fits_free = req_model_bytes_reg <= s1_free_reg;
        pend_fresh.resident  = 1'b0;
        pend_fresh.load      = s1_load_reg;
    end

    assign best_folded = fold_worker(best_reg, pend_reg);

    always_comb
    begin
        pend_item            = pend_reg;
        best_item            = best_reg;
        req_model_id_next    = req_model_id_reg;
        req_model_bytes_next = req_model_bytes_reg;
        unique case (s1_mode_reg)
            MODE_HEADER:
            begin
                pend_item            = PEND_CLEAR;
                best_item            = BEST_CLEAR;
                req_model_id_next    = s1_key_reg;
                req_model_bytes_next = s1_model_bytes_reg;
            end
            MODE_SNAPSHOT:
            begin
                best_item = best_folded;
                pend_item = pend_fresh;
            end
            MODE_RESIDENT:
            begin
                if (pend_reg.valid && (s1_key_reg == req_model_id_reg))
                begin
                    pend_item.resident = 1'b1;
                end
            end
            default:
            begin
                pend_item = pend_reg;
            end
        endcase
        if (!advance)
        begin
            req_model_id_next    = req_model_id_reg;
            req_model_bytes_next = req_model_bytes_reg;
        end
    end

    assign best_final = fold_worker(best_item, pend_item);

    always_comb
    begin
        pend_next = pend_reg;
        best_next = best_reg;
        for (int i = 0; i < NUM_TIERS; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        if (advance)
        begin
            pend_next = pend_item;
            best_next = best_item;
            if (s1_last_reg)
            begin
                pend_next = PEND_CLEAR;
                best_next = BEST_CLEAR;
                for (int i = 0; i < NUM_TIERS; i++)
                begin
                    if (best_final.valid && (best_final.rank == RANK_BITS'(i)))
                    begin
                        cnt_next[i] = cnt_reg[i] + COUNTER_BITS'(1);
                    end
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (advance && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            req_model_id_reg    <= '0;
            req_model_bytes_reg <= '0;
            pend_reg            <= PEND_CLEAR;
            best_reg            <= BEST_CLEAR;
            for (int i = 0; i < NUM_TIERS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg        <= s1_valid_next;
            out_valid_reg       <= out_valid_next;
            req_model_id_reg    <= req_model_id_next;
            req_model_bytes_reg <= req_model_bytes_next;
            pend_reg            <= pend_next;
            best_reg            <= best_next;
            for (int i = 0; i < NUM_TIERS; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    // hold the request payload
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_mode_reg        <= mode;
            s1_key_reg         <= key_id;
            s1_model_bytes_reg <= model_bytes;
            s1_ident_reg       <= worker_ident;
            s1_accepting_reg   <= accepting;
            s1_budget_reg      <= budget_bytes;
            s1_free_reg        <= free_in;
            s1_load_reg        <= LOAD_BITS'(queued) + LOAD_BITS'(active);
            s1_last_reg        <= last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_last_reg)
        begin
            status_reg         <= best_final.valid ? STATUS_CHOSEN : STATUS_NONE;
            chosen_worker_reg  <= best_final.valid ? best_final.worker : '0;
            chosen_tier_reg    <= best_final.valid ? best_final.rank : RANK_RESIDENT;
            resident_picks_reg <= cnt_next[0];
            fit_picks_reg      <= cnt_next[1];
            evict_picks_reg    <= cnt_next[2];
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign chosen_worker  = chosen_worker_reg;
    assign chosen_tier    = chosen_tier_reg;
    assign resident_picks = resident_picks_reg;
    assign fit_picks      = fit_picks_reg;
    assign evict_picks    = evict_picks_reg;

    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STATUS_NONE)) |-> ((chosen_worker == '0) && (chosen_tier == '0)))
        else $error("failed pick carries nonzero worker or tier");

    a_chosen_tier: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STATUS_CHOSEN)) |-> (chosen_tier != RANK_NONE))
        else $error("chosen worker has no tier");

    a_best_rank: assert property (@(posedge clk) disable iff (!rst_n)
        best_reg.valid |-> (best_reg.rank != RANK_NONE))
        else $error("best choice without a tier");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_last_reg) |=> (!pend_reg.valid && !best_reg.valid && out_valid_reg))
        else $error("request state not cleared after result");

endmodule

### test/tb_residency_tiered_worker_pick.sv
// Testbench for residency_tiered_worker_pick: pick scoreboard, request driver and result checker.
`timescale 1ns / 1ps

import rtwp_pkg::*;

localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;

typedef struct {
    logic [MODE_BITS-1:0]      mode;
    logic [KEY_BITS-1:0]       key;
    logic [BYTES_BITS-1:0]     need;
    logic [WORKER_ID_BITS-1:0] ident;
    logic                      accepting;
    logic [BYTES_BITS-1:0]     budget;
    logic [BYTES_BITS-1:0]     used;
    logic [COUNT_IN_BITS-1:0]  queued;
    logic [COUNT_IN_BITS-1:0]  active;
    logic                      last;
} route_item_t;

typedef struct packed {
    logic                      status;
    logic [WORKER_ID_BITS-1:0] worker;
    logic [RANK_BITS-1:0]      tier;
    logic [COUNTER_BITS-1:0]   resident_picks;
    logic [COUNTER_BITS-1:0]   fit_picks;
    logic [COUNTER_BITS-1:0]   evict_picks;
} pick_t;

class pick_scoreboard;
    logic [KEY_BITS-1:0]     model_key;
    logic [BYTES_BITS-1:0]   model_need;
    pend_t                   pend;
    best_t                   best;
    logic [COUNTER_BITS-1:0] tier_count [NUM_TIERS];
    pick_t                   picks_due [$];
    int unsigned             errors;

    function new();
        model_key = '0;
        model_need = '0;
        foreach (tier_count[i])
            tier_count[i] = '0;
        errors = 0;
        drop_request();
    endfunction

    function void drop_request();
        pend = '0;
        best.valid = 1'b0;
        best.worker = '0;
        best.rank = RANK_NONE;
        best.weight = '1;
    endfunction

    function void merge_worker();
        logic [RANK_BITS-1:0] tier;
        if (pend.valid && pend.feasible)
        begin
            tier = pend.resident ? RANK_RESIDENT : (pend.fits_free ? RANK_FIT : RANK_EVICT);
            if (!best.valid || tier < best.rank
                || (tier == best.rank && pend.load < best.weight)
                || (tier == best.rank && pend.load == best.weight && pend.id < best.worker))
            begin
                best.valid = 1'b1;
                best.worker = pend.id;
                best.rank = tier;
                best.weight = pend.load;
            end
        end
        pend.valid = 1'b0;
    endfunction

    function void note_request(route_item_t it);
        logic [BYTES_BITS-1:0] room;
        pick_t                 want;
        case (it.mode)
            MODE_HEADER:
            begin
                drop_request();
                model_key = it.key;
                model_need = it.need;
            end
            MODE_SNAPSHOT:
            begin
                room = (it.budget >= it.used) ? it.budget - it.used : '0;
                merge_worker();
                pend.valid = 1'b1;
                pend.id = it.ident;
                pend.feasible = it.accepting && (model_need <= it.budget);
                pend.fits_free = model_need <= room;
                pend.resident = 1'b0;
                pend.load = {1'b0, it.queued} + {1'b0, it.active};
            end
            MODE_RESIDENT:
            begin
                if (pend.valid && it.key == model_key)
                    pend.resident = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (it.last)
        begin
            merge_worker();
            if (best.valid)
            begin
                tier_count[best.rank] = tier_count[best.rank] + COUNTER_BITS'(1);
                want.status = STATUS_CHOSEN;
                want.worker = best.worker;
                want.tier = best.rank;
            end
            else
            begin
                want.status = STATUS_NONE;
                want.worker = '0;
                want.tier = '0;
            end
            want.resident_picks = tier_count[RANK_RESIDENT];
            want.fit_picks = tier_count[RANK_FIT];
            want.evict_picks = tier_count[RANK_EVICT];
            picks_due.push_back(want);
            drop_request();
        end
    endfunction

    function void compare_field(string name, logic [COUNTER_BITS-1:0] want,
                                logic [COUNTER_BITS-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_result(pick_t got);
        pick_t want;
        if (picks_due.size() == 0)
        begin
            $display("%0t: unexpected result: expected none, actual status %0h worker %0h",
                     $time, got.status, got.worker);
            errors++;
            return;
        end
        want = picks_due.pop_front();
        compare_field("status", COUNTER_BITS'(want.status), COUNTER_BITS'(got.status));
        compare_field("chosen_worker", COUNTER_BITS'(want.worker), COUNTER_BITS'(got.worker));
        compare_field("chosen_tier", COUNTER_BITS'(want.tier), COUNTER_BITS'(got.tier));
        compare_field("resident_picks", want.resident_picks, got.resident_picks);
        compare_field("fit_picks", want.fit_picks, got.fit_picks);
        compare_field("evict_picks", want.evict_picks, got.evict_picks);
    endfunction
endclass

module tb_residency_tiered_worker_pick;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_ITEMS    = 1700;
    localparam int QUIET_FROM      = 1400;
    localparam int HOLD_AT         = 500;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [MODE_BITS-1:0]      mode;
    logic [KEY_BITS-1:0]       key_id;
    logic [BYTES_BITS-1:0]     model_bytes;
    logic [WORKER_ID_BITS-1:0] worker_ident;
    logic                      accepting;
    logic [BYTES_BITS-1:0]     budget_bytes;
    logic [BYTES_BITS-1:0]     used_bytes;
    logic [COUNT_IN_BITS-1:0]  queued;
    logic [COUNT_IN_BITS-1:0]  active;
    logic                      last;
    logic                      out_valid;
    logic                      out_stall;
    logic                      status;
    logic [WORKER_ID_BITS-1:0] chosen_worker;
    logic [RANK_BITS-1:0]      chosen_tier;
    logic [COUNTER_BITS-1:0]   resident_picks;
    logic [COUNTER_BITS-1:0]   fit_picks;
    logic [COUNTER_BITS-1:0]   evict_picks;

    bit quiet_tail;
    bit hold_off_pending;

    pick_scoreboard sb = new();

    residency_tiered_worker_pick dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .key_id         (key_id),
        .model_bytes    (model_bytes),
        .worker_ident   (worker_ident),
        .accepting      (accepting),
        .budget_bytes   (budget_bytes),
        .used_bytes     (used_bytes),
        .queued         (queued),
        .active         (active),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .chosen_worker  (chosen_worker),
        .chosen_tier    (chosen_tier),
        .resident_picks (resident_picks),
        .fit_picks      (fit_picks),
        .evict_picks    (evict_picks)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result('{status, chosen_worker, chosen_tier,
                                  resident_picks, fit_picks, evict_picks});
            if (in_valid && !in_stall)
                sb.note_request('{mode, key_id, model_bytes, worker_ident, accepting,
                                  budget_bytes, used_bytes, queued, active, last});
        end
    end

    initial
    begin : receiver
        out_stall <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [BYTES_BITS-1:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    function automatic logic [COUNT_IN_BITS-1:0] narrow16(int hi);
        return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, hi));
    endfunction

    function automatic route_item_t noise_item();
        route_item_t it;
        it.mode = 2'($urandom_range(0, 3));
        it.key = $urandom;
        it.need = rand48();
        it.ident = 16'($urandom);
        it.accepting = 1'($urandom);
        it.budget = rand48();
        it.used = rand48();
        it.queued = 16'($urandom);
        it.active = 16'($urandom);
        it.last = ($urandom_range(0, 3) == 0);
        return it;
    endfunction

    function automatic route_item_t header_item(logic [KEY_BITS-1:0] key,
                                                logic [BYTES_BITS-1:0] need, logic fin);
        route_item_t it;
        it = noise_item();
        it.mode = MODE_HEADER;
        it.key = key;
        it.need = need;
        it.last = fin;
        return it;
    endfunction

    function automatic route_item_t worker_item(logic [WORKER_ID_BITS-1:0] ident, logic acc,
                                                logic [BYTES_BITS-1:0] budget,
                                                logic [BYTES_BITS-1:0] used,
                                                logic [COUNT_IN_BITS-1:0] q,
                                                logic [COUNT_IN_BITS-1:0] a, logic fin);
        route_item_t it;
        it = noise_item();
        it.mode = MODE_SNAPSHOT;
        it.ident = ident;
        it.accepting = acc;
        it.budget = budget;
        it.used = used;
        it.queued = q;
        it.active = a;
        it.last = fin;
        return it;
    endfunction

    function automatic route_item_t resident_item(logic [KEY_BITS-1:0] key, logic fin);
        route_item_t it;
        it = noise_item();
        it.mode = MODE_RESIDENT;
        it.key = key;
        it.last = fin;
        return it;
    endfunction

    function automatic route_item_t spare_item(logic fin);
        route_item_t it;
        it = noise_item();
        it.mode = MODE_SPARE;
        it.last = fin;
        return it;
    endfunction

    task automatic send_item(route_item_t it);
        if (!quiet_tail && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        mode <= it.mode;
        key_id <= it.key;
        model_bytes <= it.need;
        worker_ident <= it.ident;
        accepting <= it.accepting;
        budget_bytes <= it.budget;
        used_bytes <= it.used;
        queued <= it.queued;
        active <= it.active;
        last <= it.last;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic directed_requests();
        logic [BYTES_BITS-1:0] top;
        top = '1;
        send_item(resident_item(32'd0, 1'b0));
        send_item(worker_item(16'hFFFF, 1'b1, top, top, 16'hFFFF, 16'hFFFF, 1'b0));
        send_item(resident_item(32'd0, 1'b1));
        send_item(header_item(32'hFFFF_FFFF, top, 1'b1));
        send_item(header_item(32'h1234_5678, 48'd1000, 1'b0));
        send_item(worker_item(16'd5, 1'b0, top, 48'd0, 16'd0, 16'd0, 1'b0));
        send_item(worker_item(16'd7, 1'b1, 48'd999, 48'd0, 16'd0, 16'd0, 1'b0));
        send_item(worker_item(16'd9, 1'b1, 48'd1000, 48'd0, 16'd0, 16'd0, 1'b0));
        send_item(worker_item(16'd3, 1'b1, 48'd2000, 48'd3000, 16'd0, 16'd0, 1'b0));
        send_item(worker_item(16'd4, 1'b1, 48'd1000, 48'd0, 16'd0, 16'd0, 1'b0));
        send_item(worker_item(16'd4, 1'b1, 48'd1000, 48'd0, 16'd0, 16'd0, 1'b0));
        send_item(resident_item(32'h1234_5679, 1'b0));
        send_item(spare_item(1'b1));
        send_item(header_item(32'd1, 48'd0, 1'b0));
        send_item(worker_item(16'd20, 1'b1, 48'd0, top, 16'd1, 16'd0, 1'b0));
        send_item(resident_item(32'd1, 1'b0));
        send_item(worker_item(16'd10, 1'b1, 48'd0, 48'd0, 16'd0, 16'd0, 1'b0));
        send_item(worker_item(16'd0, 1'b1, top, 48'd0, 16'hFFFF, 16'hFFFF, 1'b1));
        send_item(header_item(32'd2, 48'd5, 1'b0));
        send_item(worker_item(16'd1, 1'b1, 48'd4, 48'd0, 16'd0, 16'd0, 1'b1));
        send_item(spare_item(1'b1));
        send_item(header_item(32'd3, 48'd0, 1'b0));
        send_item(resident_item(32'd3, 1'b1));
    endtask

    task automatic random_request(inout int sent);
        route_item_t           burst [$];
        logic [KEY_BITS-1:0]   key;
        logic [BYTES_BITS-1:0] need;
        logic [BYTES_BITS-1:0] budget;
        logic [BYTES_BITS-1:0] used;
        key = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 7));
        need = ($urandom_range(0, 9) == 0) ? rand48() : 48'($urandom_range(0, 4096));
        burst.push_back(header_item(key, need, 1'b0));
        if ($urandom_range(0, 19) != 0)
        begin
            repeat ($urandom_range(1, 6))
            begin
                case ($urandom_range(0, 4))
                    0: budget = need;
                    1: budget = need + 48'($urandom_range(0, 4096));
                    2: budget = need - 48'($urandom_range(1, 64));
                    3: budget = rand48();
                    default: budget = need + 48'($urandom_range(0, 64));
                endcase
                case ($urandom_range(0, 4))
                    0: used = '0;
                    1: used = budget;
                    2: used = budget - 48'($urandom_range(0, 4096));
                    3: used = rand48();
                    default: used = 48'($urandom_range(0, 4096));
                endcase
                burst.push_back(worker_item(narrow16(7), $urandom_range(0, 7) != 0,
                                            budget, used, narrow16(3), narrow16(3), 1'b0));
                repeat ($urandom_range(0, 3))
                    burst.push_back(resident_item($urandom_range(0, 1) ? key
                                                  : 32'($urandom_range(0, 7)), 1'b0));
            end
        end
        if ($urandom_range(0, 7) == 0)
            burst.push_back(spare_item(1'b0));
        burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i])
            send_item(burst[i]);
        sent += burst.size();
    endtask

    initial
    begin : stimulus
        int sent;
        bit hold_done;
        sent = 0;
        hold_done = 1'b0;
        quiet_tail = 1'b0;
        hold_off_pending = 1'b0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        mode <= MODE_HEADER;
        key_id <= '0;
        model_bytes <= '0;
        worker_ident <= '0;
        accepting <= 1'b0;
        budget_bytes <= '0;
        used_bytes <= '0;
        queued <= '0;
        active <= '0;
        last <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_requests();
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= QUIET_FROM)
                quiet_tail = 1'b1;
            if (!hold_done && sent >= HOLD_AT)
            begin
                hold_off_pending = 1'b1;
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(noise_item());
                sent++;
            end
            else
                random_request(sent);
        end
        in_valid <= 1'b0;
        while (sb.picks_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
